// File: rtl/core/anb_pkg.sv
// ----------------------------------------------------------------------------
// anb_pkg: shared types and constants of the Annex B NAL unit splitter
// Widths of packet positions and unit sizes, NAL type codes, result record.
// ----------------------------------------------------------------------------
package anb_pkg;

   localparam int MAX_PACKET_BYTES = 1048576;
   localparam int POS_W  = $clog2(MAX_PACKET_BYTES);
   localparam int SIZE_W = 21;
   localparam int OFFSET_W = 20;
   localparam int TYPE_W = 5;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PACKET_BYTES - 1);

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

   localparam logic [TYPE_W-1:0] NAL_IDR = 5'd5;
   localparam logic [TYPE_W-1:0] NAL_SEI = 5'd6;
   localparam logic [TYPE_W-1:0] NAL_SPS = 5'd7;
   localparam logic [TYPE_W-1:0] NAL_PPS = 5'd8;

   // one closed unit, as it leaves the block
   typedef struct packed {
      logic                closed_by_end;
      logic                param_set;
      logic                key_frame;
      logic [TYPE_W-1:0]   nal_type;
      logic [SIZE_W-1:0]   nal_size;
      logic [OFFSET_W-1:0] nal_offset;
   } nal_result_type;

endpackage

// File: rtl/core/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter: H.264 Annex B start-code parser
// Splits a byte stream of Annex B packets into NAL unit descriptors.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one packet byte per word; tlast marks the packet's last byte.
//   rsp_*  : one word per reported NAL unit: header offset, size (start code
//            excluded), type, IDR and parameter-set marks; tuser is set when
//            the packet end, rather than the next start code, closed the unit.
//   SEI units, empty units and bytes ahead of the first start code give no
//   word. Start codes are found at any byte alignment; one zero ahead of
//   00 00 01 belongs to a four-byte start code.
// Pipeline and throughput
//   A byte is taken into an input register and scanned there; its result
//   lands in the output register, from which the word is valid. One byte per
//   cycle while no closing byte waits for the output register, set by the
//   single scan step between the two registers.
// Reset and stall
//   Reset clears the scan state and both valid flags. While rsp_tready is low
//   with a word pending, bytes that close no unit still pass; a byte that
//   closes one waits in the input register, and req_tready drops behind it.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
   import anb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // packet_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [19:0] nal_offset, [40:20] nal_size,
                                    // [45:41] nal_type, [46] key_frame,
                                    // [47] param_set
   output logic        rsp_tuser    // closed_by_end
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;

   logic           step;
   logic           emit;
   logic           slot_free;
   nal_result_type result;
   nal_result_type rsp_data;

   // advance the held byte unless its result has nowhere to go
   assign step        = in_valid_ff && (!emit || slot_free);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // capture the byte on every accepted word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   anb_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_byte_ff),
      .packet_end (in_last_ff),
      .emit       (emit),
      .result     (result)
   );

   anb_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step && emit),
      .load_data  (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   // pack the descriptor, highest field first
   assign rsp_tdata = {rsp_data.param_set, rsp_data.key_frame, rsp_data.nal_type,
                       rsp_data.nal_size, rsp_data.nal_offset};
   assign rsp_tuser = rsp_data.closed_by_end;

endmodule

// File: rtl/core/anb_parser.sv
// ----------------------------------------------------------------------------
// anb_parser: start-code scanner and unit tracker
// Takes one registered byte per step, updates the scan state and describes
// the unit that this byte closes, if any.
// ----------------------------------------------------------------------------
module anb_parser
   import anb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,        // consume the held byte this cycle
   input  logic [7:0]     data_byte,
   input  logic           packet_end,
   output logic           emit,        // held byte closes a reportable unit
   output nal_result_type result
);

   logic [POS_W-1:0]    position_ff, position_in;
   logic [1:0]          zero_run_ff, zero_run_in;
   logic                unit_open_ff, unit_open_in;
   logic                expect_header_ff, expect_header_in;
   logic [POS_W-1:0]    unit_start_ff, unit_start_in;
   logic [TYPE_W-1:0]   unit_type_ff, unit_type_in;

   logic                start_code;
   logic                have;
   logic                by_end;
   logic [POS_W-1:0]    code_len;
   logic [POS_W-1:0]    unit_end;
   logic [SIZE_W-1:0]   size;

   always_comb begin
      // header byte opens the unit
      unit_start_in = expect_header_ff ? position_ff : unit_start_ff;
      unit_type_in  = expect_header_ff ? data_byte[TYPE_W-1:0] : unit_type_ff;
      start_code    = (data_byte == BYTE_ONE) && zero_run_ff[1];
      code_len      = (zero_run_ff == 2'd3) ? POS_W'(3) : POS_W'(2);
      unit_end      = (position_ff >= code_len) ? position_ff - code_len : '0;
      have          = 1'b0;
      by_end        = 1'b0;
      size          = '0;

      if (start_code) begin
         have = unit_open_ff | expect_header_ff;
         if (unit_end > unit_start_in) begin
            size = SIZE_W'(unit_end - unit_start_in);
         end
      end else if (packet_end && (unit_open_ff | expect_header_ff)) begin
         have   = 1'b1;
         by_end = 1'b1;
         if (position_ff >= unit_start_in) begin
            size = SIZE_W'(position_ff - unit_start_in) + SIZE_W'(1);
         end else begin
            size = SIZE_W'(1);
         end
      end

      emit = have && (size != '0) && (unit_type_in != NAL_SEI);

      result.nal_offset    = OFFSET_W'(unit_start_in);
      result.nal_size      = size;
      result.nal_type      = unit_type_in;
      result.key_frame     = (unit_type_in == NAL_IDR);
      result.param_set     = (unit_type_in == NAL_SPS) || (unit_type_in == NAL_PPS);
      result.closed_by_end = by_end;

      // next scan state
      if (start_code) begin
         zero_run_in = 2'd0;
      end else if (data_byte == BYTE_ZERO) begin
         zero_run_in = (zero_run_ff == 2'd3) ? 2'd3 : zero_run_ff + 2'd1;
      end else begin
         zero_run_in = 2'd0;
      end
      unit_open_in     = !start_code && (unit_open_ff | expect_header_ff);
      expect_header_in = start_code;
      position_in      = (position_ff < POS_LAST) ? position_ff + POS_W'(1) : POS_LAST;
      if (packet_end) begin
         zero_run_in      = 2'd0;
         unit_open_in     = 1'b0;
         expect_header_in = 1'b0;
         position_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         zero_run_ff      <= 2'd0;
         unit_open_ff     <= 1'b0;
         expect_header_ff <= 1'b0;
         unit_start_ff    <= '0;
         unit_type_ff     <= '0;
      end else if (step) begin
         position_ff      <= position_in;
         zero_run_ff      <= zero_run_in;
         unit_open_ff     <= unit_open_in;
         expect_header_ff <= expect_header_in;
         unit_start_ff    <= unit_start_in;
         unit_type_ff     <= unit_type_in;
      end
   end

endmodule

// File: rtl/core/anb_rsp_reg.sv
// ----------------------------------------------------------------------------
// anb_rsp_reg: result output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module anb_rsp_reg
   import anb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  nal_result_type load_data,
   output logic           slot_free,   // a new word may be loaded this cycle
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output nal_result_type rsp_data
);

   logic           valid_ff, valid_in;
   nal_result_type data_ff;

   assign slot_free  = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Annex B NAL unit splitter
// A short table of hand-written packets, then random well-formed packets mixed
// with noise and broken start codes. Every accepted byte goes through an
// in-bench scanner, and every unit word leaving the block is checked field by
// field against the oldest predicted unit. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import anb_pkg::*;

   localparam int NUM_DIRECTED   = 28;
   localparam int RANDOM_BYTES   = 1500;
   // a unit word passes the input and output registers after its closing byte; allow margin
   localparam int DRAIN_CYCLES   = 8;
   // longest legal quiet stretch is a sender gap, a receiver stall and a drain
   // pause; take it many times over
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTS     = 40;

   // plain non-IDR slice, used to weight the random header types
   localparam logic [TYPE_W-1:0] NAL_SLICE = 5'd1;

   localparam nal_result_type NO_UNIT = '0;

   // one row of the directed table; unit fields from msb: closed_by_end,
   // param_set, key_frame, nal_type, nal_size, nal_offset
   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      logic           typed;
      logic           emit;
      nal_result_type unit;
   } table_row_type;

   typedef struct {
      logic [7:0]     data;
      logic           last;
      bit             hold;
      bit             typed;
      bit             emit;
      nal_result_type unit;
   } byte_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // packet_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [19:0] nal_offset, [40:20] nal_size,
                                      // [45:41] nal_type, [46] key_frame,
                                      // [47] param_set
   logic        rsp_tuser;            // closed_by_end

   // Directed packets:
   //   one: 3-byte start code, SPS, 4-byte start code closes it, IDR closed
   //        by the packet end with a trailing zero counted in its size
   //   two: junk ahead of the first start code with a saturating zero run,
   //        an empty unit, an SEI unit closed by a start code on the last byte
   //   three: header byte alone on the last byte, upper header bits set
   table_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h67, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'hff, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h01, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, NAL_SPS, 21'd2, 20'd3}},
      '{8'h65, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h80, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, NAL_IDR, 21'd3, 20'd9}},
      '{8'h42, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h01, 1'b0, 1'b1, 1'b0, NO_UNIT},
      '{8'h06, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h01, 1'b1, 1'b1, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_UNIT},
      '{8'he8, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, NAL_PPS, 21'd1, 20'd3}}
   };

   byte_word_type  byte_words [$];
   nal_result_type expected_units [$];

   // scanner state, mirroring the block's
   int unsigned       scan_pos   = 0;
   int unsigned       zero_count = 0;
   bit                unit_live  = 1'b0;
   bit                header_due = 1'b0;
   int unsigned       live_start = 0;
   logic [TYPE_W-1:0] live_type  = '0;

   int unsigned accept_idx     = 0;
   int unsigned idle_cycles    = 0;
   int unsigned mismatch_count = 0;
   int unsigned bytes_accepted = 0;
   int unsigned packets_seen   = 0;
   int unsigned units_checked  = 0;
   int unsigned idr_units      = 0;
   int unsigned param_units    = 0;
   int unsigned end_closed     = 0;
   int unsigned send_calm      = 0;
   int unsigned take_calm      = 0;

   annexb_nal_unit_splitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < MAX_PRINTS) begin
         $display("mismatch: %s got %0d want %0d (unit word %0d)", what, got, want,
                  units_checked);
      end
      mismatch_count++;
   endtask

   // Scan one accepted byte; emit is set when it closes a unit worth a word.
   function automatic void scan_byte(input logic [7:0] b, input logic last,
                                     output bit emit, output nal_result_type unit);
      int unsigned       p, k, stop, size;
      bit                have, by_end;
      logic [TYPE_W-1:0] ty;
      p      = scan_pos;
      have   = 1'b0;
      by_end = 1'b0;
      size   = 0;
      ty     = live_type;

      if (header_due) begin
         live_start = p;
         live_type  = b[TYPE_W-1:0];
         unit_live  = 1'b1;
         header_due = 1'b0;
      end

      if (b == BYTE_ONE && zero_count >= 2) begin
         // one zero beyond the pair belongs to a four-byte start code
         k = (zero_count >= 3) ? 3 : 2;
         if (unit_live) begin
            stop = (p >= k) ? p - k : 0;
            size = (stop > live_start) ? stop - live_start : 0;
            ty   = live_type;
            have = 1'b1;
         end
         unit_live  = 1'b0;
         header_due = 1'b1;
         zero_count = 0;
      end else if (b == BYTE_ZERO) begin
         if (zero_count < 3) zero_count++;
      end else begin
         zero_count = 0;
      end

      if (last) begin
         if (!have && unit_live) begin
            size   = (p >= live_start) ? p + 1 - live_start : 1;
            ty     = live_type;
            have   = 1'b1;
            by_end = 1'b1;
         end
         scan_pos   = 0;
         zero_count = 0;
         unit_live  = 1'b0;
         header_due = 1'b0;
      end else begin
         scan_pos = (p < POS_LAST) ? p + 1 : POS_LAST;
      end

      emit               = have && size != 0 && ty != NAL_SEI;
      unit               = '0;
      unit.nal_offset    = OFFSET_W'(live_start);
      unit.nal_size      = SIZE_W'(size);
      unit.nal_type      = ty;
      unit.key_frame     = (ty == NAL_IDR);
      unit.param_set     = (ty == NAL_SPS) || (ty == NAL_PPS);
      unit.closed_by_end = by_end;
   endfunction

   // Wait before the next word: drawn at random, with calm stretches of no waiting.
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // zero_odds sets how often zeros and ones turn up among random bytes
   function automatic logic [7:0] random_byte(input int unsigned zero_odds);
      int unsigned pick;
      pick = $urandom_range(0, zero_odds);
      if (pick == 0) return BYTE_ZERO;
      if (pick == 1) return BYTE_ONE;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] data);
      byte_word_type w;
      w.data  = data;
      w.last  = 1'b0;
      w.hold  = 1'b0;
      w.typed = 1'b0;
      w.emit  = 1'b0;
      w.unit  = NO_UNIT;
      byte_words.push_back(w);
   endtask

   // Mostly well-formed packets with random content; the rest noise or
   // broken start codes.
   task automatic add_random_packet(input bit hold);
      int unsigned       start_idx, zeros, body;
      logic [TYPE_W-1:0] ty;
      start_idx = byte_words.size();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 20)) push_byte(random_byte(3));
      end else begin
         repeat ($urandom_range(0, 2)) push_byte(random_byte(10));
         repeat ($urandom_range(1, 4)) begin
            // mostly three- and four-byte codes, some long runs, a few broken
            case ($urandom_range(0, 15))
               0:       zeros = 1;
               1, 2:    zeros = $urandom_range(4, 6);
               default: zeros = $urandom_range(2, 3);
            endcase
            repeat (zeros) push_byte(BYTE_ZERO);
            push_byte(BYTE_ONE);
            case ($urandom_range(0, 7))
               0:       ty = NAL_IDR;
               1:       ty = NAL_SEI;
               2:       ty = NAL_SPS;
               3:       ty = NAL_PPS;
               4:       ty = NAL_SLICE;
               default: ty = TYPE_W'($urandom_range(0, 31));
            endcase
            push_byte({3'($urandom_range(0, 7)), ty});
            body = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 12);
            repeat (body) push_byte(random_byte(10));
         end
         case ($urandom_range(0, 7))
            0: begin
               push_byte(BYTE_ZERO);
               push_byte(BYTE_ZERO);
               push_byte(BYTE_ONE);
            end
            1: repeat ($urandom_range(1, 3)) push_byte(BYTE_ZERO);
            default: ;
         endcase
      end
      byte_words[byte_words.size() - 1].last = 1'b1;
      byte_words[start_idx].hold = hold;
   endtask

   // Sender: build the whole stimulus, release reset, then drive word by word.
   initial begin : sender
      int unsigned   gap;
      bit            hold, halfway_held;
      byte_word_type w;
      halfway_held = 1'b0;

      foreach (directed_rows[r]) begin
         push_byte(directed_rows[r].data);
         byte_words[r].last  = directed_rows[r].last;
         byte_words[r].typed = directed_rows[r].typed;
         byte_words[r].emit  = directed_rows[r].emit;
         byte_words[r].unit  = directed_rows[r].unit;
      end
      // drain after the table, and once more halfway through the random part
      add_random_packet(1'b1);
      while (byte_words.size() < NUM_DIRECTED + RANDOM_BYTES) begin
         hold = !halfway_held && byte_words.size() >= NUM_DIRECTED + RANDOM_BYTES / 2;
         if (hold) halfway_held = 1'b1;
         add_random_packet(hold);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < byte_words.size(); i++) begin
         w   = byte_words[i];
         gap = draw_wait(send_calm);
         // drop valid only when a pause follows; otherwise keep it high
         if (w.hold || gap != 0) begin
            req_tvalid <= 1'b0;
            if (w.hold) begin
               while (expected_units.size() != 0) @(posedge clock);
               repeat (DRAIN_CYCLES) @(posedge clock);
            end
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= w.data;
         req_tlast  <= w.last;
         // ready is settled by the falling edge; the word moves at the next rise
         do @(negedge clock); while (!req_tready);
         @(posedge clock);
      end
      req_tvalid <= 1'b0;

      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d unit words from %0d bytes in %0d packets.",
               units_checked, bytes_accepted, packets_seen);
      $display("Of those, %0d IDR, %0d parameter-set, %0d closed by the packet end.",
               idr_units, param_units, end_closed);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: stall for a random wait ahead of each unit word.
   initial begin : receiver
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(take_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
      end
   end

   // Sample both channels mid-cycle, where every signal has settled; a
   // handshake seen here completes at the next rising edge.
   always @(negedge clock) begin : observer
      bit             emit;
      nal_result_type unit, got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata, req_tlast, emit, unit);
            // table rows with a typed answer take it over the scanner's
            if (byte_words[accept_idx].typed) begin
               emit = byte_words[accept_idx].emit;
               unit = byte_words[accept_idx].unit;
            end
            if (emit) expected_units.push_back(unit);
            accept_idx++;
            bytes_accepted++;
            if (req_tlast) packets_seen++;
         end

         if (rsp_tvalid && rsp_tready) begin
            got = nal_result_type'({rsp_tuser, rsp_tdata});
            if (expected_units.size() == 0) begin
               report_mismatch("word with no unit pending, nal_offset", got.nal_offset, 0);
            end else begin
               want = expected_units.pop_front();
               if (got.nal_offset !== want.nal_offset)
                  report_mismatch("nal_offset", got.nal_offset, want.nal_offset);
               if (got.nal_size !== want.nal_size)
                  report_mismatch("nal_size", got.nal_size, want.nal_size);
               if (got.nal_type !== want.nal_type)
                  report_mismatch("nal_type", got.nal_type, want.nal_type);
               if (got.key_frame !== want.key_frame)
                  report_mismatch("key_frame", got.key_frame, want.key_frame);
               if (got.param_set !== want.param_set)
                  report_mismatch("param_set", got.param_set, want.param_set);
               if (got.closed_by_end !== want.closed_by_end)
                  report_mismatch("closed_by_end", got.closed_by_end, want.closed_by_end);
               units_checked++;
               if (want.key_frame) idr_units++;
               if (want.param_set) param_units++;
               if (want.closed_by_end) end_closed++;
            end
         end

         // watchdog: count cycles in which no word moves on either side
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("timeout: no word moved for %0d cycles, %0d units outstanding",
                        idle_cycles, expected_units.size());
               $display("Regression FAIL");
               $finish;
            end
         end
      end
   end

endmodule
